// File: rtl/lkvc_pkg.sv
`default_nettype none
package lkvc_pkg;

    localparam int OP_W       = 4;
    localparam int KEY_W      = 32;
    localparam int VALUE_W    = 64;
    localparam int TYPE_W     = 2;
    localparam int KIND_W     = 3;
    localparam int OUT_CNT_W  = 5;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [OP_W-1:0] OP_GET       = 4'd0;
    localparam logic [OP_W-1:0] OP_FILL      = 4'd1;
    localparam logic [OP_W-1:0] OP_SET       = 4'd2;
    localparam logic [OP_W-1:0] OP_DELETE    = 4'd3;
    localparam logic [OP_W-1:0] OP_EXISTS    = 4'd4;
    localparam logic [OP_W-1:0] OP_INV_KEY   = 4'd5;
    localparam logic [OP_W-1:0] OP_INV_ALL   = 4'd6;
    localparam logic [OP_W-1:0] OP_FLUSH_ALL = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR     = 4'd8;

    localparam logic [KIND_W-1:0] KIND_ACK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HIT    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FETCH  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] REG_WRITE_POLICY   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_ENTRIES = 1'd1;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_DISPATCH, S_SCAN, S_EVICT, S_EVICT2, S_INV,
        S_WALK, S_WALK_WB, S_EMIT_WB, S_EMIT_HIT, S_EMIT_MISS, S_EMIT_STW,
        S_EMIT_REM, S_ACK
    } state_t;

    typedef struct packed {
        logic              latch_in;
        logic              lookup;
        logic              touch;
        logic              set_hit;
        logic              insert;
        logic              evict;
        logic              drop;
        logic              capture;
        logic              scan_init;
        logic              scan_step;
        logic              walk_init;
        logic              walk_next;
        logic              clear_dirty_slot;
        logic              clear_all;
        logic              zero_vcnt;
        logic              zero_dcnt;
        logic              emit;
        logic [KIND_W-1:0] emit_kind;
        logic              emit_last;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            hit;
        logic            free_found;
        logic            wp;
        logic            slot_dirty;
        logic            walk_end;
        logic            scan_end;
        logic            out_free;
    } status_t;

    function automatic logic [VALUE_W-1:0] width_mask(logic [TYPE_W-1:0] t);
        logic [VALUE_W-1:0] m;
        case (t)
            2'd0:    m = 64'h0000_0000_0000_00FF;
            2'd1:    m = 64'h0000_0000_0000_FFFF;
            2'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// File: rtl/lkvc_ctrl.sv
`default_nettype none
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t st,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   is_walk;
    logic   set_wt;

    assign is_walk = (st.op == OP_INV_ALL) || (st.op == OP_FLUSH_ALL);
    assign set_wt  = (st.op == OP_SET) && st.wp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_LOOK;
            S_LOOK:     state_next = S_DISPATCH;
            S_DISPATCH: begin
                unique case (st.op) inside
                    OP_GET:    state_next = st.hit ? S_EMIT_HIT : S_EMIT_MISS;
                    OP_FILL: begin
                        if (st.hit) state_next = S_ACK;
                        else state_next = st.free_found ? S_ACK : S_SCAN;
                    end
                    OP_SET: begin
                        if (st.hit || st.free_found) state_next = set_wt ? S_EMIT_STW : S_ACK;
                        else state_next = S_SCAN;
                    end
                    OP_DELETE:  state_next = S_EMIT_REM;
                    OP_INV_KEY: state_next = st.hit ? S_INV : S_ACK;
                    OP_INV_ALL, OP_FLUSH_ALL: state_next = S_WALK;
                    default:    state_next = S_ACK;
                endcase
            end
            S_SCAN:     if (st.scan_end) state_next = S_EVICT;
            S_EVICT:    state_next = S_EVICT2;
            S_EVICT2: begin
                if (st.slot_dirty) state_next = S_EMIT_WB;
                else state_next = set_wt ? S_EMIT_STW : S_ACK;
            end
            S_INV:      state_next = st.slot_dirty ? S_EMIT_WB : S_ACK;
            S_WALK: begin
                if (st.slot_dirty) state_next = S_WALK_WB;
                else if (st.walk_end) state_next = S_ACK;
            end
            S_WALK_WB:  state_next = S_EMIT_WB;
            S_EMIT_WB: begin
                if (st.out_free) begin
                    if (is_walk) state_next = st.walk_end ? S_ACK : S_WALK;
                    else state_next = set_wt ? S_EMIT_STW : S_ACK;
                end
            end
            S_EMIT_HIT, S_EMIT_MISS: if (st.out_free) state_next = S_IDLE;
            S_EMIT_STW, S_EMIT_REM:  if (st.out_free) state_next = S_ACK;
            S_ACK:      if (st.out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:     cmd.latch_in = in_valid;
            S_LOOK:     cmd.lookup = 1'b1;
            S_DISPATCH: begin
                unique case (st.op) inside
                    OP_GET:  cmd.touch = st.hit;
                    OP_FILL: begin
                        cmd.insert    = !st.hit && st.free_found;
                        cmd.scan_init = !st.hit && !st.free_found;
                    end
                    OP_SET: begin
                        cmd.set_hit   = st.hit;
                        cmd.insert    = !st.hit && st.free_found;
                        cmd.scan_init = !st.hit && !st.free_found;
                    end
                    OP_DELETE:  cmd.drop = st.hit;
                    OP_INV_ALL: begin
                        cmd.walk_init = 1'b1;
                        cmd.zero_vcnt = 1'b1;
                        cmd.zero_dcnt = 1'b1;
                    end
                    OP_FLUSH_ALL: begin
                        cmd.walk_init = 1'b1;
                        cmd.zero_dcnt = 1'b1;
                    end
                    OP_CLEAR: begin
                        cmd.clear_all = 1'b1;
                        cmd.zero_vcnt = 1'b1;
                        cmd.zero_dcnt = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_SCAN:     cmd.scan_step = 1'b1;
            S_EVICT:    ;
            S_EVICT2: begin
                cmd.capture = 1'b1;
                cmd.insert  = 1'b1;
                cmd.evict   = 1'b1;
            end
            S_INV: begin
                cmd.capture = 1'b1;
                cmd.drop    = 1'b1;
            end
            S_WALK: begin
                if (!st.slot_dirty) begin
                    if (st.walk_end) cmd.clear_all = (st.op == OP_INV_ALL);
                    else cmd.walk_next = 1'b1;
                end
            end
            S_WALK_WB: begin
                cmd.capture          = 1'b1;
                cmd.clear_dirty_slot = 1'b1;
            end
            S_EMIT_WB: begin
                cmd.emit      = st.out_free;
                cmd.emit_kind = KIND_WRITE;
                if (st.out_free && is_walk) begin
                    if (st.walk_end) cmd.clear_all = (st.op == OP_INV_ALL);
                    else cmd.walk_next = 1'b1;
                end
            end
            S_EMIT_HIT: begin
                cmd.emit      = st.out_free;
                cmd.emit_kind = KIND_HIT;
                cmd.emit_last = 1'b1;
            end
            S_EMIT_MISS: begin
                cmd.emit      = st.out_free;
                cmd.emit_kind = KIND_FETCH;
                cmd.emit_last = 1'b1;
            end
            S_EMIT_STW: begin
                cmd.emit      = st.out_free;
                cmd.emit_kind = KIND_WRITE;
            end
            S_EMIT_REM: begin
                cmd.emit      = st.out_free;
                cmd.emit_kind = KIND_REMOVE;
            end
            S_ACK: begin
                cmd.emit      = st.out_free;
                cmd.emit_kind = KIND_ACK;
                cmd.emit_last = 1'b1;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/lkvc_dpath.sv
`default_nettype none
module lkvc_dpath
    import lkvc_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cmd_t                  cmd,
    output status_t                    st,
    input  wire logic [OP_W-1:0]       in_op,
    input  wire logic [KEY_W-1:0]      in_key,
    input  wire logic [VALUE_W-1:0]    in_value,
    input  wire logic [TYPE_W-1:0]     in_type,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic [KIND_W-1:0]          out_kind,
    output logic [KEY_W-1:0]           out_key,
    output logic [VALUE_W-1:0]         out_value,
    output logic [TYPE_W-1:0]          out_type,
    output logic                       out_present,
    output logic [OUT_CNT_W-1:0]       out_live_count,
    output logic [OUT_CNT_W-1:0]       out_dirty_count,
    output logic                       out_last
);

    localparam int TAG_W  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int WORD_W = TYPE_W + VALUE_W;

    // Configuration
    logic                 wp_reg;
    logic [CFG_DATA_W-1:0] ae_reg;
    logic [CNT_W-1:0]     lim;
    logic [IDX_W-1:0]     lim_m1;

    // Latched item
    logic [OP_W-1:0]      op_reg;
    logic [TAG_W-1:0]     key_reg;
    logic [VALUE_W-1:0]   val_reg;
    logic [TYPE_W-1:0]    vt_reg;

    // Entry state
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [ENTRIES-1:0]   dirty_reg, dirty_next;
    logic [IDX_W-1:0]     rank_reg [ENTRIES];
    logic [IDX_W-1:0]     rank_next [ENTRIES];
    logic [TAG_W-1:0]     tag_reg [ENTRIES];
    logic [CNT_W-1:0]     vcnt_reg, vcnt_next;
    logic [CNT_W-1:0]     dcnt_reg, dcnt_next;
    logic [WORD_W-1:0]    mem [ENTRIES];
    logic [WORD_W-1:0]    rdata_reg;

    // Lookup, scan and write-back capture
    logic                 hit_reg, present_reg, free_found_reg;
    logic [IDX_W-1:0]     slot_reg;
    logic [IDX_W-1:0]     scan_reg, best_reg;
    logic [IDX_W-1:0]     best_rank_reg;
    logic [TAG_W-1:0]     wb_key_reg;
    logic [WORD_W-1:0]    wb_word_reg;

    logic                 hit_any, free_any;
    logic [IDX_W-1:0]     hit_idx, free_idx, victim;
    logic [IDX_W-1:0]     rs;
    logic                 mark_dirty;
    logic                 mem_we;
    logic                 out_valid_reg;
    logic                 wb_pending_reg;

    always_comb begin
        if (ae_reg == '0) lim = CNT_W'(1);
        else if (int'(ae_reg) > ENTRIES) lim = CNT_W'(ENTRIES);
        else lim = CNT_W'(ae_reg);
    end
    assign lim_m1 = IDX_W'(lim - CNT_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            ae_reg <= CFG_DATA_W'(16);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_WRITE_POLICY:   wp_reg <= cfg_wdata[0];
                REG_ACTIVE_ENTRIES: ae_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg  <= in_op;
            key_reg <= in_key[TAG_W-1:0];
            val_reg <= in_value & width_mask(in_type);
            vt_reg  <= in_type;
        end
    end

    // Parallel tag compare and first free slot below the allocation limit.
    always_comb begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int j = ENTRIES - 1; j >= 0; j--) begin
            if (valid_reg[j] && (tag_reg[j] == key_reg)) begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(j);
            end
            if (!valid_reg[j] && (j < int'(lim))) begin
                free_any = 1'b1;
                free_idx = IDX_W'(j);
            end
        end
    end

    assign victim = (rank_reg[scan_reg] > best_rank_reg) ? scan_reg : best_reg;

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            hit_reg        <= hit_any;
            present_reg    <= hit_any && (op_reg <= OP_INV_KEY);
            free_found_reg <= free_any;
        end
        if (cmd.lookup) slot_reg <= hit_any ? hit_idx : free_idx;
        else if (cmd.scan_step && (scan_reg == lim_m1)) slot_reg <= victim;
        else if (cmd.walk_init) slot_reg <= '0;
        else if (cmd.walk_next) slot_reg <= slot_reg + IDX_W'(1);
        if (cmd.scan_init) begin
            scan_reg      <= '0;
            best_reg      <= '0;
            best_rank_reg <= rank_reg[0];
        end else if (cmd.scan_step) begin
            scan_reg      <= scan_reg + IDX_W'(1);
            best_reg      <= victim;
            best_rank_reg <= rank_reg[victim];
        end
        if (cmd.capture) begin
            wb_key_reg  <= tag_reg[slot_reg];
            wb_word_reg <= rdata_reg;
        end
    end

    assign rs         = rank_reg[slot_reg];
    assign mark_dirty = (op_reg == OP_SET) && !wp_reg;
    assign mem_we     = cmd.insert || cmd.set_hit;

    always_comb begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        rank_next  = rank_reg;
        vcnt_next  = vcnt_reg;
        dcnt_next  = dcnt_reg;
        if (cmd.touch || cmd.set_hit) begin
            for (int j = 0; j < ENTRIES; j++) begin
                if (valid_reg[j] && (rank_reg[j] < rs)) rank_next[j] = rank_reg[j] + IDX_W'(1);
            end
            rank_next[slot_reg] = '0;
        end
        if (cmd.set_hit) begin
            if (wp_reg) begin
                if (dirty_reg[slot_reg]) begin
                    dirty_next[slot_reg] = 1'b0;
                    dcnt_next            = dcnt_reg - CNT_W'(1);
                end
            end else if (!dirty_reg[slot_reg]) begin
                dirty_next[slot_reg] = 1'b1;
                dcnt_next            = dcnt_reg + CNT_W'(1);
            end
        end
        if (cmd.drop) begin
            for (int j = 0; j < ENTRIES; j++) begin
                if ((j != int'(slot_reg)) && valid_reg[j] && (rank_reg[j] > rs))
                    rank_next[j] = rank_reg[j] - IDX_W'(1);
            end
            valid_next[slot_reg] = 1'b0;
            dirty_next[slot_reg] = 1'b0;
            rank_next[slot_reg]  = '0;
            vcnt_next = vcnt_reg - CNT_W'(1);
            dcnt_next = dcnt_reg - CNT_W'(dirty_reg[slot_reg]);
        end
        if (cmd.insert) begin
            // An eviction drops the victim and ages the rest in one step.
            for (int j = 0; j < ENTRIES; j++) begin
                if ((j != int'(slot_reg)) && valid_reg[j])
                    rank_next[j] = rank_reg[j] + IDX_W'(1)
                                 - IDX_W'(cmd.evict && (rank_reg[j] > rs));
            end
            valid_next[slot_reg] = 1'b1;
            dirty_next[slot_reg] = mark_dirty;
            rank_next[slot_reg]  = '0;
            if (!cmd.evict) vcnt_next = vcnt_reg + CNT_W'(1);
            dcnt_next = dcnt_reg - CNT_W'(cmd.evict && dirty_reg[slot_reg])
                      + CNT_W'(mark_dirty);
        end
        if (cmd.clear_dirty_slot) dirty_next[slot_reg] = 1'b0;
        if (cmd.clear_all) begin
            valid_next = '0;
            dirty_next = '0;
            for (int j = 0; j < ENTRIES; j++) rank_next[j] = '0;
        end
        if (cmd.zero_vcnt) vcnt_next = '0;
        if (cmd.zero_dcnt) dcnt_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            dirty_reg <= '0;
            vcnt_reg  <= '0;
            dcnt_reg  <= '0;
            for (int j = 0; j < ENTRIES; j++) rank_reg[j] <= '0;
        end else begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            vcnt_reg  <= vcnt_next;
            dcnt_reg  <= dcnt_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert) tag_reg[slot_reg] <= key_reg;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[slot_reg] <= {vt_reg, val_reg};
        rdata_reg <= mem[slot_reg];
    end

    // A store write for a set comes from the item; eviction, invalidate and flush
    // write-backs come from the captured entry. A captured dirty entry stays pending
    // until its write-back is sent, so the set's own write is the one seen with none pending.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_pending_reg <= 1'b0;
        end else if (cmd.capture) begin
            wb_pending_reg <= dirty_reg[slot_reg];
        end else if (cmd.emit && (cmd.emit_kind == KIND_WRITE)) begin
            wb_pending_reg <= 1'b0;
        end else if (cmd.latch_in) begin
            wb_pending_reg <= 1'b0;
        end
    end

    function automatic logic state_is_stw(cmd_t c);
        return !wb_pending_reg && !c.emit_last;
    endfunction

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_kind        <= cmd.emit_kind;
            out_last        <= cmd.emit_last;
            out_present     <= present_reg;
            out_live_count  <= OUT_CNT_W'(vcnt_next);
            out_dirty_count <= OUT_CNT_W'(dcnt_next);
            case (cmd.emit_kind)
                KIND_HIT: begin
                    out_key   <= KEY_W'(key_reg);
                    out_value <= rdata_reg[VALUE_W-1:0];
                    out_type  <= rdata_reg[WORD_W-1:VALUE_W];
                end
                KIND_FETCH: begin
                    out_key   <= KEY_W'(key_reg);
                    out_value <= '0;
                    out_type  <= vt_reg;
                end
                KIND_WRITE: begin
                    if ((op_reg == OP_SET) && (state_is_stw(cmd))) begin
                        out_key   <= KEY_W'(key_reg);
                        out_value <= val_reg;
                        out_type  <= vt_reg;
                    end else begin
                        out_key   <= KEY_W'(wb_key_reg);
                        out_value <= wb_word_reg[VALUE_W-1:0];
                        out_type  <= wb_word_reg[WORD_W-1:VALUE_W];
                    end
                end
                default: begin
                    out_key   <= KEY_W'(key_reg);
                    out_value <= '0;
                    out_type  <= '0;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign st.op         = op_reg;
    assign st.hit        = hit_reg;
    assign st.free_found = free_found_reg;
    assign st.wp         = wp_reg;
    assign st.slot_dirty = dirty_reg[slot_reg];
    assign st.walk_end   = (slot_reg == IDX_W'(ENTRIES - 1));
    assign st.scan_end   = (scan_reg == lim_m1);
    assign st.out_free   = !out_valid_reg || out_ready;

    a_vcnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vcnt_reg <= CNT_W'(ENTRIES))
        else $error("entry count above capacity");
    a_dirty_le_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        dcnt_reg <= vcnt_reg)
        else $error("dirty count above entry count");
    a_dirty_subset: assert property (@(posedge aclk) disable iff (!aresetn)
        (dirty_reg & ~valid_reg) == '0)
        else $error("dirty bit on an invalid entry");
    a_insert_mru: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |=> (valid_reg[$past(slot_reg)] && (rank_reg[$past(slot_reg)] == '0)))
        else $error("inserted entry is not most recent");

endmodule
`default_nettype wire

// File: rtl/lru_write_back_key_value_cache.sv
// Fully associative LRU key/value cache with write-back or write-through sets.
//
// Channels: items enter on the s_ stream (op, key and value in s_tdata, value
// type in s_tuser) and each item produces one or more result transfers on the
// m_ stream. m_tlast marks the final result of an item; m_tuser carries the
// result kind and the value width code. Configuration is a plain write port
// (write_policy at index 0, active_entries at index 1), written while idle.
//
// Items are processed one at a time. After the input transfer an item passes
// through the lookup and decode states; a get's result is then registered from
// its emit state, and the next item is accepted back in idle. Each further
// result has its own emit state, which waits while the output register is
// full. An allocation that must evict scans the LRU ranks one slot per cycle
// over the active slots. Flush all and invalidate all walk every slot, one per
// cycle for clean slots; a dirty slot's write-back is sent before moving on.
//
// Reset clears all valid, dirty and rank state at once; no clearing pass.
// When the receiver stalls, the result register holds and the sequencer waits;
// the next item is taken as soon as the last result is loaded into the output
// register, so that register decouples the two sides.
`default_nettype none
module lru_write_back_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [103:0]          s_tdata,  // op[3:0], key[35:4], value[99:36], zero pad
    input  wire logic [1:0]            s_tuser,  // value_type[1:0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [111:0]               m_tdata,  // out_key[31:0], out_value[95:32],
                                                 // present[96], live_count[101:97],
                                                 // dirty_count[106:102], zero pad
    output logic [4:0]                 m_tuser,  // kind[2:0], out_type[4:3]
    output logic                       m_tlast,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cmd_t                  cmd;
    status_t               st;
    logic [KIND_W-1:0]     kind;
    logic [KEY_W-1:0]      okey;
    logic [VALUE_W-1:0]    oval;
    logic [TYPE_W-1:0]     otype;
    logic                  opresent;
    logic [OUT_CNT_W-1:0]  ecount, dcount;

    // The controller sequences each op; the datapath holds all entry state.
    lkvc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lkvc_dpath #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .st              (st),
        .in_op           (s_tdata[3:0]),
        .in_key          (s_tdata[35:4]),
        .in_value        (s_tdata[99:36]),
        .in_type         (s_tuser),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_kind        (kind),
        .out_key         (okey),
        .out_value       (oval),
        .out_type        (otype),
        .out_present     (opresent),
        .out_live_count  (ecount),
        .out_dirty_count (dcount),
        .out_last        (m_tlast)
    );

    // Result packing, highest field first.
    assign m_tdata = {5'd0, dcount, ecount, opresent, oval, okey};
    assign m_tuser = {otype, kind};

endmodule
`default_nettype wire
